// ----- rtl/slr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the stereo linear resampler.
// No dependencies; every other file of the block refers to this package.
package slr_pkg;

    localparam int CHANNELS  = 2;
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 16;
    localparam int REG_W     = 16;
    localparam int PROD_W    = SAMPLE_W + PHASE_W;
    localparam int SUM_W     = SAMPLE_W + 2;
    localparam int DIV_STEPS = PROD_W - PHASE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_STEP_NUM = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_STEP_DEN = 1'b1;

    // Output clamp limits.
    localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -18'sd32768;
    localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 18'sd32767;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [CHANNELS-1:0]     t_frame;
    typedef logic [PHASE_W-1:0]         t_phase;

    // One output point to compute: channel 0 is left, channel 1 is right.
    typedef struct packed {
        t_frame prev;
        t_frame next;
        t_phase phase;
        t_phase den;
        logic   last;
    } t_cmd;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_RUN
    } t_front_state;

    typedef enum logic [2:0] {
        BACK_IDLE,
        BACK_MUL,
        BACK_START,
        BACK_DIV,
        BACK_DONE
    } t_back_state;

endpackage

// ----- rtl/slr_ifs.sv -----
`timescale 1ns / 1ps
// Handshake interfaces of the stereo linear resampler: source frames,
// result frames and configuration writes. Depends on slr_pkg.
interface slr_src_if;
    logic              valid;
    logic              ready;
    slr_pkg::t_sample  src_left;
    slr_pkg::t_sample  src_right;

    modport source (output valid, src_left, src_right, input ready);
    modport sink   (input valid, src_left, src_right, output ready);
endinterface

interface slr_res_if;
    logic              valid;
    logic              ready;
    slr_pkg::t_sample  out_left;
    slr_pkg::t_sample  out_right;
    logic              run_last;

    modport source (output valid, out_left, out_right, run_last, input ready);
    modport sink   (input valid, out_left, out_right, run_last, output ready);
endinterface

interface slr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [slr_pkg::REG_IDX_W-1:0]   index;
    logic [slr_pkg::REG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/slr_front.sv -----
`timescale 1ns / 1ps
// Front end of the resampler: accepts source frames, keeps the previous
// frame and the phase, and walks each run into output commands. Uses slr_pkg.
module slr_front #(
    parameter int MAX_RUN = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    slr_src_if.sink         i_src,
    input  slr_pkg::t_phase i_num,
    input  slr_pkg::t_phase i_den,
    output logic            o_cmd_valid,
    output slr_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_ready
);

    localparam int CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int PW    = slr_pkg::PHASE_W;

    slr_pkg::t_front_state r_state, n_state;
    logic                  r_primed, n_primed;
    slr_pkg::t_phase       r_phase, n_phase;
    slr_pkg::t_frame       r_prev, n_prev;
    slr_pkg::t_frame       r_next, n_next;
    slr_pkg::t_phase       r_p, n_p;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    slr_pkg::t_frame       w_src;
    logic [PW:0]           w_step;
    logic [PW+1:0]         w_over;
    logic                  w_reached;
    logic                  w_last;

    assign w_src[0] = i_src.src_left;
    assign w_src[1] = i_src.src_right;

    // Phase after this output, and the same less den: its sign ends the run.
    assign w_step    = {1'b0, r_p} + {1'b0, i_num};
    assign w_over    = {1'b0, w_step} - {2'b00, i_den};
    assign w_reached = ~w_over[PW+1];
    assign w_last    = w_reached || (r_cnt == CNT_W'(MAX_RUN - 1));

    assign i_src.ready = (r_state == slr_pkg::FRONT_IDLE);
    assign o_cmd_valid = (r_state == slr_pkg::FRONT_RUN);
    assign o_cmd       = '{prev: r_prev, next: r_next, phase: r_p, den: i_den,
                           last: w_last};

    always_comb begin
        n_state  = r_state;
        n_primed = r_primed;
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_next   = r_next;
        n_p      = r_p;
        n_cnt    = r_cnt;
        case (r_state)
            slr_pkg::FRONT_IDLE: begin
                if (i_src.valid) begin
                    if (!r_primed) begin
                        n_prev   = w_src;
                        n_phase  = '0;
                        n_primed = 1'b1;
                    end else if (r_phase >= i_den) begin
                        // Downsampling skip: no output for this frame.
                        n_phase = r_phase - i_den;
                        n_prev  = w_src;
                    end else begin
                        n_next  = w_src;
                        n_p     = r_phase;
                        n_cnt   = '0;
                        n_state = slr_pkg::FRONT_RUN;
                    end
                end
            end
            slr_pkg::FRONT_RUN: begin
                if (i_cmd_ready) begin
                    if (w_last) begin
                        n_phase = w_reached ? w_over[PW-1:0] : '0;
                        n_prev  = r_next;
                        n_state = slr_pkg::FRONT_IDLE;
                    end else begin
                        n_p   = w_step[PW-1:0];
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = slr_pkg::FRONT_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= slr_pkg::FRONT_IDLE;
            r_primed <= 1'b0;
            r_phase  <= '0;
            r_prev   <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_primed <= n_primed;
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next <= n_next;
        r_p    <= n_p;
    end

`ifndef SYNTHESIS
    // Every point handed on lies in the interval: its phase is below den.
    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slr_pkg::FRONT_RUN) |-> (r_p < i_den))
        else $error("front: run phase not below denominator");
`endif

endmodule

// ----- rtl/slr_queue.sv -----
`timescale 1ns / 1ps
// Short command queue between the front and back ends of the resampler.
// Uses slr_pkg for the command type.
module slr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slr_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output slr_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slr_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    // Equal pointers only when the queue is empty or full.
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) |-> (r_count == '0 || r_count == CNT_W'(DEPTH)))
        else $error("queue: pointers and fill count disagree");
`endif

endmodule

// ----- rtl/slr_div.sv -----
`timescale 1ns / 1ps
// Restoring divider of the resampler, one quotient bit per cycle.
// The quotient must fit in PHASE_W bits. Uses slr_pkg.
module slr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [slr_pkg::PROD_W-1:0]  i_dividend,
    input  slr_pkg::t_phase             i_divisor,
    output logic                        o_done,
    output slr_pkg::t_phase             o_quotient
);

    localparam int PW = slr_pkg::PHASE_W;
    localparam int CW = slr_pkg::DIV_CNT_W;

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    slr_pkg::t_phase r_rem;
    slr_pkg::t_phase r_quo;
    slr_pkg::t_phase r_den;
    logic [PW:0]     w_trial;
    logic [PW:0]     w_diff;
    logic            w_fit;

    assign w_trial    = {r_rem, r_quo[PW-1]};
    assign w_diff     = w_trial - {1'b0, r_den};
    assign w_fit      = (w_trial >= {1'b0, r_den});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(slr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[slr_pkg::PROD_W-1:PW];
            r_quo <= i_dividend[PW-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[PW-1:0] : w_trial[PW-1:0];
            r_quo <= {r_quo[PW-2:0], w_fit};
        end
    end

endmodule

// ----- rtl/slr_back.sv -----
`timescale 1ns / 1ps
// Back end of the resampler: computes one interpolated stereo point per
// command and holds it in the output register. Uses slr_pkg and slr_div.
module slr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  slr_pkg::t_cmd i_cmd,
    output logic          o_cmd_ready,
    slr_res_if.source     o_res
);

    localparam int SW = slr_pkg::SAMPLE_W;
    localparam int PW = slr_pkg::PHASE_W;
    localparam int NC = slr_pkg::CHANNELS;

    slr_pkg::t_back_state r_state, n_state;
    slr_pkg::t_cmd        r_cmd;
    logic [NC-1:0]        r_neg;
    logic [slr_pkg::PROD_W-1:0] r_prod [NC];
    logic [NC-1:0]        w_done;
    slr_pkg::t_phase      w_quo [NC];
    slr_pkg::t_sample     w_res [NC];
    logic                 w_start;
    logic                 w_load;

    logic                 r_out_valid;
    slr_pkg::t_sample     r_out_left;
    slr_pkg::t_sample     r_out_right;
    logic                 r_out_last;

    assign o_cmd_ready = (r_state == slr_pkg::BACK_IDLE);
    assign w_start     = (r_state == slr_pkg::BACK_START);
    assign w_load      = (r_state == slr_pkg::BACK_DONE) && (!r_out_valid || o_res.ready);

    for (genvar g = 0; g < NC; g++) begin : g_lane
        logic signed [SW:0]                 w_diff;
        logic signed [SW:0]                 w_mag;
        logic signed [slr_pkg::SUM_W-1:0]   w_sq;
        logic signed [slr_pkg::SUM_W-1:0]   w_sum;

        assign w_diff = $signed({r_cmd.next[g][SW-1], r_cmd.next[g]})
                      - $signed({r_cmd.prev[g][SW-1], r_cmd.prev[g]});
        assign w_mag  = w_diff[SW] ? -w_diff : w_diff;

        always_ff @(posedge i_clk) begin
            if (r_state == slr_pkg::BACK_MUL) begin
                r_neg[g]  <= w_diff[SW];
                r_prod[g] <= slr_pkg::PROD_W'(w_mag[SW-1:0])
                           * slr_pkg::PROD_W'(r_cmd.phase);
            end
        end

        slr_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (w_start),
            .i_dividend (r_prod[g]),
            .i_divisor  (r_cmd.den),
            .o_done     (w_done[g]),
            .o_quotient (w_quo[g])
        );

        // Truncation toward zero: divide the magnitude, then restore the sign.
        assign w_sq  = r_neg[g] ? -$signed({2'b00, w_quo[g]}) : $signed({2'b00, w_quo[g]});
        assign w_sum = slr_pkg::SUM_W'($signed(r_cmd.prev[g])) + w_sq;

        always_comb begin
            if (w_sum > slr_pkg::SAMPLE_MAX) begin
                w_res[g] = slr_pkg::SAMPLE_MAX[SW-1:0];
            end else if (w_sum < slr_pkg::SAMPLE_MIN) begin
                w_res[g] = slr_pkg::SAMPLE_MIN[SW-1:0];
            end else begin
                w_res[g] = w_sum[SW-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            slr_pkg::BACK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = slr_pkg::BACK_MUL;
                end
            end
            slr_pkg::BACK_MUL: begin
                n_state = slr_pkg::BACK_START;
            end
            slr_pkg::BACK_START: begin
                n_state = slr_pkg::BACK_DIV;
            end
            slr_pkg::BACK_DIV: begin
                if (w_done[0]) begin
                    n_state = slr_pkg::BACK_DONE;
                end
            end
            slr_pkg::BACK_DONE: begin
                if (w_load) begin
                    n_state = slr_pkg::BACK_IDLE;
                end
            end
            default: begin
                n_state = slr_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slr_pkg::BACK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == slr_pkg::BACK_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (w_load) begin
            r_out_left  <= w_res[0];
            r_out_right <= w_res[1];
            r_out_last  <= r_cmd.last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_left  = r_out_left;
    assign o_res.out_right = r_out_right;
    assign o_res.run_last  = r_out_last;

`ifndef SYNTHESIS
    // The channel dividers start together and so must finish together.
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_done) == (|w_done))
        else $error("back: divider lanes out of step");

    // The quotient fits the divider only while the phase is below den.
    for (genvar a = 0; a < NC; a++) begin : g_chk
        a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == slr_pkg::BACK_START) |->
                (r_prod[a][slr_pkg::PROD_W-1:PW] < r_cmd.den))
            else $error("back: quotient would overflow the divider");
    end

    // The result state is only entered from the divide state, or held.
    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slr_pkg::BACK_DONE) |-> ($past(r_state) == slr_pkg::BACK_DIV ||
                                             $past(r_state) == slr_pkg::BACK_DONE))
        else $error("back: result state entered out of order");
`endif

endmodule

// ----- rtl/stereo_linear_resampler.sv -----
`timescale 1ns / 1ps
// Top level of the stereo linear-interpolation resampler.
// Depends on slr_pkg, slr_ifs, slr_front, slr_queue, slr_back and slr_div.

// Each source frame on i_src yields the output frames that lie on the line
// between the previous source frame and this one, at phases p, p+num,
// p+2*num... below den, p being the phase left from earlier frames, with the
// quotient truncated toward zero. The first frame after reset yields nothing,
// and a frame whose phase is already at or above den is skipped. A frame
// that yields k outputs (at most MAX_RUN) is walked by the front end at one
// command per cycle while the queue has room, but only QUEUE_DEPTH commands
// fit in the queue, so the input stays stalled until the run's last command
// is queued. The back end takes a new command only when done with the last;
// the bit-serial divider sets its pace (take the command, multiply, start,
// one divide step per quotient bit, see the divider finish, hand over to the
// output register), and it waits longer while a stalled receiver holds the
// output register. The command queue lets the front accept the next frame
// while the back end is still working through the tail of the previous run.
// The run_last flag marks the final output of each frame. Registers
// step_numerator (index 0) and step_denominator (index 1) both reset to 1,
// a value of 0 acts as 1, and the user must see that they are written only
// while the block is idle; the block itself does not enforce this.
module stereo_linear_resampler #(
    parameter int MAX_RUN     = 64,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slr_src_if.sink   i_src,
    slr_res_if.source o_res,
    slr_cfg_if.sink   i_cfg
);

    logic [slr_pkg::REG_W-1:0] r_step_num;
    logic [slr_pkg::REG_W-1:0] r_step_den;
    slr_pkg::t_phase           w_num;
    slr_pkg::t_phase           w_den;

    logic          w_fq_valid;
    logic          w_fq_ready;
    slr_pkg::t_cmd w_fq_cmd;
    logic          w_qb_valid;
    logic          w_qb_ready;
    slr_pkg::t_cmd w_qb_cmd;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_num <= slr_pkg::REG_W'(1);
            r_step_den <= slr_pkg::REG_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                slr_pkg::REG_STEP_NUM: r_step_num <= i_cfg.data;
                slr_pkg::REG_STEP_DEN: r_step_den <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // A zero step value behaves as one.
    assign w_num = (r_step_num == '0) ? slr_pkg::PHASE_W'(1) : r_step_num;
    assign w_den = (r_step_den == '0) ? slr_pkg::PHASE_W'(1) : r_step_den;

    slr_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src       (i_src),
        .i_num       (w_num),
        .i_den       (w_den),
        .o_cmd_valid (w_fq_valid),
        .o_cmd       (w_fq_cmd),
        .i_cmd_ready (w_fq_ready)
    );

    slr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_valid),
        .i_cmd   (w_fq_cmd),
        .o_ready (w_fq_ready),
        .o_valid (w_qb_valid),
        .o_cmd   (w_qb_cmd),
        .i_pop   (w_qb_ready)
    );

    slr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_qb_valid),
        .i_cmd       (w_qb_cmd),
        .o_cmd_ready (w_qb_ready),
        .o_res       (o_res)
    );

endmodule
